[src/rrpa_pkg.sv]
// ----------------------------------------------------------------------------
// rrpa_pkg
// Shared types and constants for the route-record pad and append block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrpa_pkg;

  localparam int CNT_W       = 4;   // list count width
  localparam int IDX_W       = 3;   // list index width on the result
  localparam int SNR_IN_W    = 12;  // input SNR, 1/16 dB
  localparam int SNR_Q_W     = 8;   // SNR byte, quarter dB
  localparam int ID_W        = 32;  // node identifier width
  localparam int ROUTE_DEPTH = 8;   // entries per list

  localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(ROUTE_DEPTH);
  localparam logic [ID_W-1:0]  UNKNOWN_HOP = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0]  UNKNOWN_SNR = 32'h0000_0080;

  typedef enum logic [1:0] {
    KIND_ROUTE   = 2'd0,
    KIND_SNR     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // result of the shared count unit
  typedef struct packed {
    logic             lt;   // count below limit
    logic [CNT_W-1:0] inc;  // count plus one
  } cnt_res_t;

endpackage

`default_nettype wire

[src/route_record_pad_and_append.sv]
// ----------------------------------------------------------------------------
// route_record_pad_and_append
// Pads a relayed route record with unknown hops and SNR markers, then
// appends this node's SNR and ID, one list write per result transfer.
// ----------------------------------------------------------------------------
// One header is taken at a time; in_stall stays high until its summary has
// been loaded into the output register. A small sequencer steps one shared
// compare/increment unit once per cycle while the output register can take
// a result: one step per entry written, one step to leave each padding phase
// (only when the hop counters are valid), one step for the SNR append, one
// for the own-ID append unless SNR only, and one for the summary. While the
// sink stalls a waiting result, the sequencer holds its step. The next
// header is accepted while the summary still waits in the output register.
// own_node_id is written through the cfg_ channel; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module route_record_pad_and_append (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rrpa_pkg::ID_W-1:0]        cfg_own_node_id,
  // header input
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [2:0]                       in_hop_init,
  input  wire logic [2:0]                       in_hop_left,
  input  wire logic [rrpa_pkg::CNT_W-1:0]       in_route_len,
  input  wire logic [rrpa_pkg::CNT_W-1:0]       in_snr_len,
  input  wire logic                             in_towards_destination,
  input  wire logic                             in_snr_only,
  input  wire logic signed [rrpa_pkg::SNR_IN_W-1:0] in_snr_sixteenth_db,
  // results
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_entry_kind,
  output logic                                  out_back_path,
  output logic [rrpa_pkg::IDX_W-1:0]            out_entry_index,
  output logic [rrpa_pkg::ID_W-1:0]             out_entry_value,
  output logic [rrpa_pkg::CNT_W-1:0]            out_new_route_len,
  output logic [rrpa_pkg::CNT_W-1:0]            out_new_snr_len,
  output logic                                  out_route_overflow,
  output logic                                  out_last
);
  import rrpa_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_PAD_RT  = 6'b000010,  // pad route list up to hops taken
    ST_PAD_SNR = 6'b000100,  // pad SNR list up to route count
    ST_APP_SNR = 6'b001000,  // append measured SNR
    ST_APP_RT  = 6'b010000,  // append own ID
    ST_SUMM    = 6'b100000   // summary transfer
  } state_t;

  state_t state_r, state_nxt;

  // working registers for the header in flight
  logic [ID_W-1:0]    own_id_r;
  logic [CNT_W-1:0]   rc_r, rc_nxt;
  logic [CNT_W-1:0]   sc_r, sc_nxt;
  logic [CNT_W-1:0]   tgt_r;
  logic [SNR_Q_W-1:0] q_r;
  logic               back_r;
  logic               snr_only_r;
  logic               ovf_r, ovf_nxt;

  // output register
  logic               out_valid_r;
  kind_t              kind_r;
  logic               back_o_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ID_W-1:0]    val_r;
  logic [CNT_W-1:0]   nrc_r;
  logic [CNT_W-1:0]   nsc_r;
  logic               novf_r;
  logic               last_r;

  // shared unit and SNR converter
  logic [CNT_W-1:0]   cu_cnt, cu_lim;
  cnt_res_t           cu_res;
  logic [SNR_Q_W-1:0] snr_q;

  rrpa_cnt_unit u_cnt (
    .cnt (cu_cnt),
    .lim (cu_lim),
    .res (cu_res)
  );

  rrpa_snr_conv u_snr (
    .snr_in (in_snr_sixteenth_db),
    .snr_q  (snr_q)
  );

  logic             in_xfer;
  logic             step_en;
  logic             emit;
  kind_t            e_kind;
  logic [IDX_W-1:0] e_idx;
  logic [ID_W-1:0]  e_val;
  logic             pad_ok;
  logic [2:0]       taken;
  logic [CNT_W-1:0] tgt_in;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  // the sequencer steps only when the output register can take a result
  assign step_en   = (state_r != ST_IDLE) && (!out_valid_r || !out_stall);

  // hop counters valid: start known and limit not above start
  assign pad_ok = (in_hop_init != 3'd0) && (in_hop_left <= in_hop_init);
  assign taken  = in_hop_init - in_hop_left;
  assign tgt_in = ({1'b0, taken} < DEPTH_CNT) ? {1'b0, taken} : DEPTH_CNT;

  // operand select for the shared unit
  always_comb begin
    cu_cnt = rc_r;
    cu_lim = DEPTH_CNT;
    case (state_r)
      ST_PAD_RT: begin
        cu_cnt = rc_r;
        cu_lim = tgt_r;
      end
      ST_PAD_SNR: begin
        cu_cnt = sc_r;
        cu_lim = (rc_r < DEPTH_CNT) ? rc_r : DEPTH_CNT;
      end
      ST_APP_SNR: begin
        cu_cnt = sc_r;
        cu_lim = DEPTH_CNT;
      end
      ST_APP_RT: begin
        cu_cnt = rc_r;
        cu_lim = DEPTH_CNT;
      end
      default: begin
        cu_cnt = rc_r;
        cu_lim = DEPTH_CNT;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rc_nxt    = rc_r;
    sc_nxt    = sc_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    e_kind    = KIND_SUMMARY;
    e_idx     = '0;
    e_val     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          rc_nxt    = in_route_len;
          sc_nxt    = in_snr_len;
          ovf_nxt   = 1'b0;
          state_nxt = pad_ok ? ST_PAD_RT : ST_APP_SNR;
        end
      end
      ST_PAD_RT: begin
        if (step_en) begin
          if (cu_res.lt) begin
            emit   = 1'b1;
            e_kind = KIND_ROUTE;
            e_idx  = rc_r[IDX_W-1:0];
            e_val  = UNKNOWN_HOP;
            rc_nxt = cu_res.inc;
          end else begin
            state_nxt = ST_PAD_SNR;
          end
        end
      end
      ST_PAD_SNR: begin
        if (step_en) begin
          if (cu_res.lt) begin
            emit   = 1'b1;
            e_kind = KIND_SNR;
            e_idx  = sc_r[IDX_W-1:0];
            e_val  = UNKNOWN_SNR;
            sc_nxt = cu_res.inc;
          end else begin
            state_nxt = ST_APP_SNR;
          end
        end
      end
      ST_APP_SNR: begin
        if (step_en) begin
          // full SNR list drops the measurement silently
          if (cu_res.lt) begin
            emit   = 1'b1;
            e_kind = KIND_SNR;
            e_idx  = sc_r[IDX_W-1:0];
            e_val  = {{(ID_W-SNR_Q_W){1'b0}}, q_r};
            sc_nxt = cu_res.inc;
          end
          state_nxt = snr_only_r ? ST_SUMM : ST_APP_RT;
        end
      end
      ST_APP_RT: begin
        if (step_en) begin
          if (cu_res.lt) begin
            emit   = 1'b1;
            e_kind = KIND_ROUTE;
            e_idx  = rc_r[IDX_W-1:0];
            e_val  = own_id_r;
            rc_nxt = cu_res.inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = ST_SUMM;
        end
      end
      ST_SUMM: begin
        if (step_en) begin
          emit      = 1'b1;
          e_kind    = KIND_SUMMARY;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      own_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        own_id_r <= cfg_own_node_id;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and payload registers, no reset needed
  always_ff @(posedge clk) begin
    rc_r  <= rc_nxt;
    sc_r  <= sc_nxt;
    ovf_r <= ovf_nxt;
    if (in_xfer) begin
      tgt_r      <= tgt_in;
      q_r        <= snr_q;
      back_r     <= ~in_towards_destination;
      snr_only_r <= in_snr_only;
    end
    if (emit) begin
      kind_r   <= e_kind;
      back_o_r <= back_r;
      idx_r    <= e_idx;
      val_r    <= e_val;
      // summary fields read zero on entry transfers
      if (e_kind == KIND_SUMMARY) begin
        nrc_r  <= rc_r;
        nsc_r  <= sc_r;
        novf_r <= ovf_r;
        last_r <= 1'b1;
      end else begin
        nrc_r  <= '0;
        nsc_r  <= '0;
        novf_r <= 1'b0;
        last_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_entry_kind      = kind_r;
  assign out_back_path       = back_o_r;
  assign out_entry_index     = idx_r;
  assign out_entry_value     = val_r;
  assign out_new_route_len   = nrc_r;
  assign out_new_snr_len     = nsc_r;
  assign out_route_overflow  = novf_r;
  assign out_last            = last_r;

`ifndef SYNTH
  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_entry_kind == KIND_SUMMARY))
    else $error("last set on a non-summary transfer");

  a_entry_no_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_entry_kind == KIND_ROUTE || out_entry_kind == KIND_SNR))
    |-> (!out_last && !out_route_overflow && out_new_route_len == '0 &&
         out_new_snr_len == '0))
    else $error("summary fields set on an entry transfer");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_PAD_RT || state_r == ST_APP_SNR))
    else $error("header accepted but sequencer did not start");

  a_summary_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUMM && step_en) |=> (out_valid && out_last && !in_stall))
    else $error("summary step did not load the output register");
`endif

endmodule

`default_nettype wire

[src/rrpa_cnt_unit.sv]
// ----------------------------------------------------------------------------
// rrpa_cnt_unit
// Shared compare and increment unit, stepped by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rrpa_cnt_unit (
  input  wire logic [rrpa_pkg::CNT_W-1:0] cnt,
  input  wire logic [rrpa_pkg::CNT_W-1:0] lim,
  output rrpa_pkg::cnt_res_t              res
);
  import rrpa_pkg::*;

  always_comb begin
    res.lt  = (cnt < lim);
    res.inc = cnt + CNT_W'(1);
  end

endmodule

`default_nettype wire

[src/rrpa_snr_conv.sv]
// ----------------------------------------------------------------------------
// rrpa_snr_conv
// SNR from 1/16 dB to quarter dB, truncated toward zero, saturated to a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rrpa_snr_conv (
  input  wire logic signed [rrpa_pkg::SNR_IN_W-1:0] snr_in,
  output logic [rrpa_pkg::SNR_Q_W-1:0]              snr_q
);
  import rrpa_pkg::*;

  localparam logic signed [SNR_IN_W-1:0] Q_MAX = SNR_IN_W'(127);
  localparam logic signed [SNR_IN_W-1:0] Q_MIN = -SNR_IN_W'(128);

  logic signed [SNR_IN_W-1:0] biased;
  logic signed [SNR_IN_W-1:0] quot;

  always_comb begin
    // bias negatives by 3 so the arithmetic shift rounds toward zero
    biased = snr_in + $signed({{(SNR_IN_W-2){1'b0}}, snr_in[SNR_IN_W-1],
                               snr_in[SNR_IN_W-1]});
    quot   = biased >>> 2;
    if (quot > Q_MAX) begin
      snr_q = Q_MAX[SNR_Q_W-1:0];
    end else if (quot < Q_MIN) begin
      snr_q = Q_MIN[SNR_Q_W-1:0];
    end else begin
      snr_q = quot[SNR_Q_W-1:0];
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives route_record_pad_and_append with relayed route-record headers and
// checks every list write and summary against a local prediction of the
// padding and append rules, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module testbench;
  import rrpa_pkg::*;

  localparam int PERIOD_NS = 8;
  localparam int SETTLE    = 24;        // settle time after the last result
  localparam int LIMIT     = 2_000_000; // cycle budget for the whole run

  // one incoming header
  typedef struct {
    logic [2:0]              hop_init;
    logic [2:0]              hop_left;
    logic [CNT_W-1:0]        route_len;
    logic [CNT_W-1:0]        snr_len;
    logic                    towards;
    logic                    snr_only;
    logic signed [SNR_IN_W-1:0] snr;
  } header_t;

  // one list write or summary as it should leave the block
  typedef struct {
    kind_t            kind;
    logic             back;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  value;
    logic [CNT_W-1:0] route_cnt;
    logic [CNT_W-1:0] snr_cnt;
    logic             ovf;
    logic             last;
  } list_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [ID_W-1:0]        cfg_own_node_id = '0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [2:0]             in_hop_init = '0;
  logic [2:0]             in_hop_left = '0;
  logic [CNT_W-1:0]       in_route_len = '0;
  logic [CNT_W-1:0]       in_snr_len = '0;
  logic                   in_towards_destination = 1'b0;
  logic                   in_snr_only = 1'b0;
  logic signed [SNR_IN_W-1:0] in_snr_sixteenth_db = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_entry_kind;
  logic                   out_back_path;
  logic [IDX_W-1:0]       out_entry_index;
  logic [ID_W-1:0]        out_entry_value;
  logic [CNT_W-1:0]       out_new_route_len;
  logic [CNT_W-1:0]       out_new_snr_len;
  logic                   out_route_overflow;
  logic                   out_last;

  // expected list writes and summaries, oldest first
  list_write_t route_updates_due[$];
  logic [ID_W-1:0] node_id_shadow = '0;   // mirrors own_node_id, reset 0
  bit  idle_on = 1'b1;                    // random gaps/stalls enabled
  int  errors = 0;
  int  cycles = 0;
  int  n_headers = 0;
  int  n_results = 0;
  int  n_padded = 0;
  int  n_overflow = 0;
  int  n_id_writes = 0;

  route_record_pad_and_append u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_own_node_id        (cfg_own_node_id),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_hop_init            (in_hop_init),
    .in_hop_left            (in_hop_left),
    .in_route_len           (in_route_len),
    .in_snr_len             (in_snr_len),
    .in_towards_destination (in_towards_destination),
    .in_snr_only            (in_snr_only),
    .in_snr_sixteenth_db    (in_snr_sixteenth_db),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_entry_kind         (out_entry_kind),
    .out_back_path          (out_back_path),
    .out_entry_index        (out_entry_index),
    .out_entry_value        (out_entry_value),
    .out_new_route_len      (out_new_route_len),
    .out_new_snr_len        (out_new_snr_len),
    .out_route_overflow     (out_route_overflow),
    .out_last               (out_last)
  );

  initial begin
    forever #(PERIOD_NS / 2) clk = ~clk;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due", $time, cycles,
               route_updates_due.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long. Shared by the
  // source (cycles between headers) and the sink (stall runs).
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(30, 80);
  endfunction

  // Sink stall pattern: alternate free runs (sometimes long) with stall runs.
  initial begin : sink_stall
    int free_left;
    int stall_left;
    free_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!idle_on || !rst_n) begin
        out_stall <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 8);
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  function automatic void push_write(kind_t kind, logic back, int idx, logic [ID_W-1:0] value,
                                     int rc, int sc, logic ovf, logic last);
    list_write_t w;
    w.kind      = kind;
    w.back      = back;
    w.idx       = idx[IDX_W-1:0];
    w.value     = value;
    w.route_cnt = rc[CNT_W-1:0];
    w.snr_cnt   = sc[CNT_W-1:0];
    w.ovf       = ovf;
    w.last      = last;
    route_updates_due.insert(route_updates_due.size(), w);
  endfunction

  // Works out every list write one header causes, in write order, then the
  // summary: pad route with unknown hops up to hops taken, pad SNR up to the
  // route count, append the quarter-dB SNR, then this node's ID.
  function automatic void predict_route_update(header_t h);
    int   rc;
    int   sc;
    int   target;
    int   quarter;
    logic back;
    logic ovf;
    back = ~h.towards;
    rc = int'(h.route_len);
    sc = int'(h.snr_len);
    ovf = 1'b0;
    if (h.hop_init != 3'd0 && h.hop_left <= h.hop_init) begin
      n_padded++;
      target = int'(h.hop_init) - int'(h.hop_left);
      if (target > ROUTE_DEPTH) target = ROUTE_DEPTH;
      while (rc < target) begin
        push_write(KIND_ROUTE, back, rc, UNKNOWN_HOP, 0, 0, 1'b0, 1'b0);
        rc++;
      end
      target = (rc < ROUTE_DEPTH) ? rc : ROUTE_DEPTH;
      while (sc < target) begin
        push_write(KIND_SNR, back, sc, UNKNOWN_SNR, 0, 0, 1'b0, 1'b0);
        sc++;
      end
    end
    // integer division truncates toward zero, then clamp to a signed byte
    quarter = int'(h.snr) / 4;
    if (quarter > 127) quarter = 127;
    if (quarter < -128) quarter = -128;
    if (sc < ROUTE_DEPTH) begin
      push_write(KIND_SNR, back, sc, {24'h0, quarter[7:0]}, 0, 0, 1'b0, 1'b0);
      sc++;
    end
    if (!h.snr_only) begin
      if (rc < ROUTE_DEPTH) begin
        push_write(KIND_ROUTE, back, rc, node_id_shadow, 0, 0, 1'b0, 1'b0);
        rc++;
      end else begin
        ovf = 1'b1;
        n_overflow++;
      end
    end
    push_write(KIND_SUMMARY, back, 0, '0, rc, sc, ovf, 1'b1);
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    list_write_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (route_updates_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual kind %0d value %0h",
                 $time, out_entry_kind, out_entry_value);
      end else begin
        w = route_updates_due.pop_front();
        n_results++;
        check_field("entry_kind", 32'(w.kind), 32'(out_entry_kind));
        check_field("back_path", 32'(w.back), 32'(out_back_path));
        check_field("entry_index", 32'(w.idx), 32'(out_entry_index));
        check_field("entry_value", w.value, out_entry_value);
        check_field("new_route_len", 32'(w.route_cnt), 32'(out_new_route_len));
        check_field("new_snr_len", 32'(w.snr_cnt), 32'(out_new_snr_len));
        check_field("route_overflow", 32'(w.ovf), 32'(out_route_overflow));
        check_field("last", 32'(w.last), 32'(out_last));
      end
    end
  end

  // One header transfer. Called at a rising edge; returns at a rising edge
  // with in_valid still high when no gap follows.
  task automatic send_header(input header_t h);
    int gap;
    in_hop_init            <= h.hop_init;
    in_hop_left            <= h.hop_left;
    in_route_len           <= h.route_len;
    in_snr_len             <= h.snr_len;
    in_towards_destination <= h.towards;
    in_snr_only            <= h.snr_only;
    in_snr_sixteenth_db    <= h.snr;
    in_valid               <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_route_update(h);
    n_headers++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has arrived, then let
  // the sequencer settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (route_updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_id(input logic [ID_W-1:0] id);
    drain_block();
    cfg_own_node_id <= id;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_id_shadow = id;
    n_id_writes++;
  endtask

  function automatic header_t make_header(int hs, int hl, int rc, int sc, bit tow, bit so,
                                          int snr);
    header_t h;
    h.hop_init  = hs[2:0];
    h.hop_left  = hl[2:0];
    h.route_len = rc[CNT_W-1:0];
    h.snr_len   = sc[CNT_W-1:0];
    h.towards   = tow;
    h.snr_only  = so;
    h.snr       = snr[SNR_IN_W-1:0];
    return h;
  endfunction

  // Mostly well-formed headers (valid hop counters, counts within depth),
  // some with broken hop counters, some with every field fully random.
  function automatic header_t random_header();
    header_t h;
    int r;
    int hs;
    int hl;
    r = $urandom_range(0, 99);
    h.towards  = 1'($urandom_range(0, 1));
    h.snr_only = ($urandom_range(0, 3) == 0);
    h.snr      = SNR_IN_W'($urandom);
    if (r < 75) begin
      hs = $urandom_range(1, 7);
      hl = $urandom_range(0, hs);
      h.hop_init  = 3'(hs);
      h.hop_left  = 3'(hl);
      h.route_len = CNT_W'($urandom_range(0, 1) ? $urandom_range(0, hs - hl)
                                                : $urandom_range(0, 8));
      h.snr_len   = CNT_W'($urandom_range(0, 8));
    end else if (r < 85) begin
      hs = $urandom_range(0, 6);
      h.hop_init  = 3'(hs);
      h.hop_left  = 3'($urandom_range(hs + 1, 7));
      h.route_len = CNT_W'($urandom_range(0, 8));
      h.snr_len   = CNT_W'($urandom_range(0, 8));
    end else begin
      h.hop_init  = 3'($urandom);
      h.hop_left  = 3'($urandom);
      h.route_len = CNT_W'($urandom);
      h.snr_len   = CNT_W'($urandom);
    end
    return h;
  endfunction

  // own_node_id must come out of reset as zero
  task automatic test_reset_node_id();
    send_header(make_header(3, 1, 0, 0, 1, 0, 160));
    send_header(make_header(0, 0, 2, 2, 0, 0, -40));
  endtask

  // Hand-picked corners of the padding, capping and SNR conversion rules.
  task automatic test_directed_corners();
    write_node_id(32'hA5C3_0F01);
    send_header(make_header(7, 0, 0, 0, 1, 0, 2047));   // deepest padding, SNR clamps high
    send_header(make_header(7, 0, 0, 0, 0, 1, -2048));  // same, SNR only, clamps low
    send_header(make_header(0, 5, 3, 1, 1, 0, 100));    // unknown hop start: no padding
    send_header(make_header(2, 5, 1, 1, 0, 0, -100));   // limit above start: no padding
    send_header(make_header(5, 5, 4, 2, 1, 0, 4));      // no hops taken, SNR padded to route
    send_header(make_header(7, 1, 2, 7, 1, 0, 0));      // SNR list already longer
    send_header(make_header(4, 0, 8, 8, 1, 0, 40));     // both full: SNR dropped, overflow
    send_header(make_header(4, 0, 8, 8, 1, 1, 40));     // both full, SNR only: no overflow
    send_header(make_header(6, 0, 15, 12, 0, 0, 64));   // counts past depth pass through
    send_header(make_header(6, 0, 9, 3, 1, 0, -64));    // route past depth, SNR padded to cap
    send_header(make_header(1, 0, 7, 7, 1, 0, -1));     // truncation toward zero
    send_header(make_header(1, 1, 0, 0, 0, 0, -4));
    send_header(make_header(1, 1, 0, 0, 1, 0, 3));
    send_header(make_header(1, 1, 0, 0, 1, 0, 511));
    send_header(make_header(1, 1, 0, 0, 1, 0, 508));
    send_header(make_header(1, 1, 0, 0, 0, 0, -509));
    send_header(make_header(1, 1, 0, 0, 0, 0, -512));   // measured SNR equals unknown marker
    send_header(make_header(1, 1, 0, 0, 1, 0, -520));
    send_header(make_header(3, 0, 7, 0, 1, 0, 200));    // last free slot in both lists
    send_header(make_header(7, 0, 3, 8, 0, 0, -300));   // route padded, SNR list full
  endtask

  task automatic test_random_traffic(input logic [ID_W-1:0] id, input int count,
                                     input bit gaps);
    write_node_id(id);
    idle_on = gaps;
    repeat (count) send_header(random_header());
    drain_block();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_node_id();
    test_directed_corners();
    test_random_traffic(32'hFFFF_FFFF, 70, 1'b1);
    test_random_traffic(32'h0000_0000, 60, 1'b0);   // back-to-back, no stalls
    test_random_traffic($urandom, 60, 1'b1);
    test_random_traffic(32'h8000_0001, 60, 1'b1);
    drain_block();

    $display("Covered %0d headers (%0d with valid hop counters, %0d route overflows),",
             n_headers, n_padded, n_overflow);
    $display("%0d result transfers checked across %0d node ID settings.", n_results,
             n_id_writes + 1);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
